// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the joystick motor mixer checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define JMM_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define JMM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JMM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/jmm_pkg.sv
// ---------------------------------------------------------------------------
// Joystick motor mixer package
// Widths, constants, sequencer types and duty helpers shared by the block.
// ---------------------------------------------------------------------------
`default_nettype none

package jmm_pkg;

   // Axis format: two's complement fraction, full scale means 1.0.
   localparam int AXIS_BITS      = 16;
   localparam int FRAC_BITS      = AXIS_BITS - 1;
   localparam int MAG_BITS       = AXIS_BITS + 1;
   localparam int SQ_BITS        = 2 * AXIS_BITS;
   localparam logic [MAG_BITS-1:0] AXIS_FULL = MAG_BITS'(1) << FRAC_BITS;

   // Duty format.
   localparam int PWM_RANGE      = 5;
   localparam int DUTY_BITS      = 3;
   localparam int DUTY_CALC_BITS = SQ_BITS + 8;
   localparam logic [DUTY_BITS-1:0] DUTY_FULL = DUTY_BITS'(PWM_RANGE);

   // tan(22.5 deg) as an unsigned 0.32 fraction.
   localparam int TAN_BITS = 32;
   localparam logic [TAN_BITS-1:0] TAN_22_5 = 32'd1779033704;

   // Shared multiplier.
   localparam int MUL_A_BITS = MAG_BITS;
   localparam int MUL_B_BITS = TAN_BITS;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

   // Square root unit: one result bit per step.
   localparam int ROOT_STEPS     = AXIS_BITS;
   localparam int ROOT_IDX_BITS  = $clog2(ROOT_STEPS);

   // Buttons.
   localparam int BTN_BITS   = 9;
   localparam int BTN_LED    = 3;
   localparam int BTN_SPIN_L = 6;
   localparam int BTN_SPIN_R = 7;
   localparam int BTN_QUIT   = 8;

   // Configuration port.
   localparam int DZ_BITS        = 15;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = DZ_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STICK_DZ = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERT_DZ  = 8'd1;
   localparam logic [DZ_BITS-1:0] DZ_RESET = 15'd1638;

   // Motor channels, in result order.
   localparam int CH_COUNT     = 6;
   localparam int CH_LEFT_FWD  = 0;
   localparam int CH_LEFT_REV  = 1;
   localparam int CH_RIGHT_FWD = 2;
   localparam int CH_RIGHT_REV = 3;
   localparam int CH_DOWN      = 4;
   localparam int CH_UP        = 5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_U,
      ST_SUM,
      ST_ROOT,
      ST_SCALE,
      ST_TAN_A,
      ST_TAN_X,
      ST_APPLY
   } state_type;

   typedef enum logic [2:0] {
      MUL_XX,
      MUL_UU,
      MUL_SCALE,
      MUL_TAN_A,
      MUL_TAN_X
   } mul_sel_type;

   typedef struct packed {
      logic                     idle;
      mul_sel_type              mul_sel;
      logic                     sum_en;
      logic                     root_load;
      logic                     root_step;
      logic [ROOT_IDX_BITS-1:0] root_idx;
      logic                     scale_en;
      logic                     steep_en;
      logic                     apply;
   } ctrl_type;

   // Magnitude of a signed axis value, one bit wider so full scale fits.
   function automatic logic [MAG_BITS-1:0] mag_of(logic [AXIS_BITS-1:0] v);
      logic [MAG_BITS-1:0] e;
      e = {v[AXIS_BITS-1], v};
      return v[AXIS_BITS-1] ? (~e + MAG_BITS'(1)) : e;
   endfunction

   // Duty of a magnitude with FRAC_BITS fraction bits, saturated.
   function automatic logic [DUTY_BITS-1:0] duty_q1(logic [MAG_BITS-1:0] mag);
      logic [DUTY_CALC_BITS-1:0] q;
      q = (DUTY_CALC_BITS'(PWM_RANGE) * DUTY_CALC_BITS'(mag)) >> FRAC_BITS;
      if (q > DUTY_CALC_BITS'(PWM_RANGE)) begin
         q = DUTY_CALC_BITS'(PWM_RANGE);
      end
      return q[DUTY_BITS-1:0];
   endfunction

   // Duty of a product of two such fractions, saturated.
   function automatic logic [DUTY_BITS-1:0] duty_q2(logic [SQ_BITS-1:0] mag);
      logic [DUTY_CALC_BITS-1:0] q;
      q = (DUTY_CALC_BITS'(PWM_RANGE) * DUTY_CALC_BITS'(mag)) >> (2 * FRAC_BITS);
      if (q > DUTY_CALC_BITS'(PWM_RANGE)) begin
         q = DUTY_CALC_BITS'(PWM_RANGE);
      end
      return q[DUTY_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// File: src/jmm_if.sv
// ---------------------------------------------------------------------------
// Joystick motor mixer channels
// Valid/ready channels for samples, results and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface jmm_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [jmm_pkg::AXIS_BITS-1:0]    stick_x;
   logic signed [jmm_pkg::AXIS_BITS-1:0]    stick_y;
   logic signed [jmm_pkg::AXIS_BITS-1:0]    vertical_axis;
   logic signed [jmm_pkg::AXIS_BITS-1:0]    spare_axis;
   logic        [jmm_pkg::BTN_BITS-1:0]     buttons;

   modport source (output valid, stick_x, stick_y, vertical_axis, spare_axis, buttons,
                   input ready);
   modport sink (input valid, stick_x, stick_y, vertical_axis, spare_axis, buttons,
                 output ready);
endinterface

interface jmm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [jmm_pkg::DUTY_BITS-1:0]     left_forward_duty;
   logic [jmm_pkg::DUTY_BITS-1:0]     left_reverse_duty;
   logic [jmm_pkg::DUTY_BITS-1:0]     right_forward_duty;
   logic [jmm_pkg::DUTY_BITS-1:0]     right_reverse_duty;
   logic [jmm_pkg::DUTY_BITS-1:0]     center_down_duty;
   logic [jmm_pkg::DUTY_BITS-1:0]     center_up_duty;
   logic                              lamp_on;
   logic                              quit_request;

   modport source (output valid, left_forward_duty, left_reverse_duty,
                   right_forward_duty, right_reverse_duty, center_down_duty,
                   center_up_duty, lamp_on, quit_request, input ready);
   modport sink (input valid, left_forward_duty, left_reverse_duty,
                 right_forward_duty, right_reverse_duty, center_down_duty,
                 center_up_duty, lamp_on, quit_request, output ready);
endinterface

interface jmm_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [jmm_pkg::CSR_INDEX_BITS-1:0]     index;
   logic [jmm_pkg::CSR_DATA_BITS-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/jmm_mul.sv
// ---------------------------------------------------------------------------
// Shared multiplier
// Selects one operand pair per cycle and registers the product.
// ---------------------------------------------------------------------------
`default_nettype none

module jmm_mul (
   input  logic                               clock,
   input  jmm_pkg::mul_sel_type               sel,
   input  logic [jmm_pkg::MAG_BITS-1:0]       x_mag,
   input  logic [jmm_pkg::MAG_BITS-1:0]       u_mag,
   input  logic [jmm_pkg::MAG_BITS-1:0]       radius,
   output logic [jmm_pkg::PROD_BITS-1:0]      prod
);

   logic [jmm_pkg::MUL_A_BITS-1:0] a;
   logic [jmm_pkg::MUL_B_BITS-1:0] b;
   logic [jmm_pkg::PROD_BITS-1:0]  prod_ff;

   // The weaker side's weight is 1 - |x| in both upper sectors.
   always_comb begin
      unique case (sel)
         jmm_pkg::MUL_XX: begin
            a = x_mag;
            b = jmm_pkg::MUL_B_BITS'(x_mag);
         end
         jmm_pkg::MUL_UU: begin
            a = u_mag;
            b = jmm_pkg::MUL_B_BITS'(u_mag);
         end
         jmm_pkg::MUL_SCALE: begin
            a = radius;
            b = jmm_pkg::MUL_B_BITS'(jmm_pkg::AXIS_FULL - x_mag);
         end
         jmm_pkg::MUL_TAN_A: begin
            a = u_mag;
            b = jmm_pkg::TAN_22_5;
         end
         jmm_pkg::MUL_TAN_X: begin
            a = x_mag;
            b = jmm_pkg::TAN_22_5;
         end
         default: begin
            a = '0;
            b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= jmm_pkg::PROD_BITS'(a) * jmm_pkg::PROD_BITS'(b);
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// File: src/jmm_root.sv
// ---------------------------------------------------------------------------
// Integer square root unit
// Digit-by-digit root, one result bit per step under sequencer control.
// ---------------------------------------------------------------------------
`default_nettype none

module jmm_root (
   input  logic                                 clock,
   input  logic                                 load,
   input  logic                                 step,
   input  logic [jmm_pkg::ROOT_IDX_BITS-1:0]    idx,
   input  logic [jmm_pkg::SQ_BITS-1:0]          radicand,
   output logic [jmm_pkg::MAG_BITS-1:0]         root
);

   logic [jmm_pkg::SQ_BITS-1:0] rem_ff;
   logic [jmm_pkg::SQ_BITS-1:0] rem_in;
   logic [jmm_pkg::SQ_BITS-1:0] res_ff;
   logic [jmm_pkg::SQ_BITS-1:0] res_in;
   logic [jmm_pkg::SQ_BITS-1:0] weight;
   logic [jmm_pkg::SQ_BITS-1:0] trial;

   assign weight = jmm_pkg::SQ_BITS'(1) << {idx, 1'b0};
   assign trial  = res_ff + weight;

   always_comb begin
      rem_in = rem_ff;
      res_in = res_ff;
      if (load) begin
         rem_in = radicand;
         res_in = '0;
      end else if (step) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + weight;
         end else begin
            res_in = res_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign root = res_ff[jmm_pkg::MAG_BITS-1:0];

endmodule

`default_nettype wire

// File: src/jmm_seq.sv
// ---------------------------------------------------------------------------
// Mixer sequencer
// Steps one sample through the multiplier and square root unit.
// ---------------------------------------------------------------------------
`default_nettype none

module jmm_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               out_free,
   output jmm_pkg::ctrl_type  ctrl
);

   jmm_pkg::state_type state_ff;
   jmm_pkg::state_type state_in;
   logic [jmm_pkg::ROOT_IDX_BITS-1:0] cnt_ff;
   logic [jmm_pkg::ROOT_IDX_BITS-1:0] cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         jmm_pkg::ST_IDLE: begin
            if (start) begin
               state_in = jmm_pkg::ST_SQ_X;
            end
         end
         jmm_pkg::ST_SQ_X: state_in = jmm_pkg::ST_SQ_U;
         jmm_pkg::ST_SQ_U: state_in = jmm_pkg::ST_SUM;
         jmm_pkg::ST_SUM: begin
            state_in = jmm_pkg::ST_ROOT;
            cnt_in   = jmm_pkg::ROOT_IDX_BITS'(jmm_pkg::ROOT_STEPS - 1);
         end
         jmm_pkg::ST_ROOT: begin
            if (cnt_ff == '0) begin
               state_in = jmm_pkg::ST_SCALE;
            end else begin
               cnt_in = cnt_ff - jmm_pkg::ROOT_IDX_BITS'(1);
            end
         end
         jmm_pkg::ST_SCALE: state_in = jmm_pkg::ST_TAN_A;
         jmm_pkg::ST_TAN_A: state_in = jmm_pkg::ST_TAN_X;
         jmm_pkg::ST_TAN_X: state_in = jmm_pkg::ST_APPLY;
         jmm_pkg::ST_APPLY: begin
            if (out_free) begin
               state_in = jmm_pkg::ST_IDLE;
            end
         end
         default: state_in = jmm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl           = '0;
      ctrl.mul_sel   = jmm_pkg::MUL_XX;
      ctrl.root_idx  = cnt_ff;
      unique case (state_ff)
         jmm_pkg::ST_IDLE:  ctrl.idle = 1'b1;
         jmm_pkg::ST_SQ_X:  ctrl.mul_sel = jmm_pkg::MUL_XX;
         jmm_pkg::ST_SQ_U: begin
            ctrl.mul_sel = jmm_pkg::MUL_UU;
            ctrl.sum_en  = 1'b1;
         end
         jmm_pkg::ST_SUM:   ctrl.root_load = 1'b1;
         jmm_pkg::ST_ROOT:  ctrl.root_step = 1'b1;
         jmm_pkg::ST_SCALE: ctrl.mul_sel = jmm_pkg::MUL_SCALE;
         jmm_pkg::ST_TAN_A: begin
            ctrl.mul_sel  = jmm_pkg::MUL_TAN_A;
            ctrl.scale_en = 1'b1;
         end
         jmm_pkg::ST_TAN_X: begin
            ctrl.mul_sel  = jmm_pkg::MUL_TAN_X;
            ctrl.steep_en = 1'b1;
         end
         jmm_pkg::ST_APPLY: begin
            // Keep the last product in place while the result stage is full.
            ctrl.mul_sel = jmm_pkg::MUL_TAN_X;
            ctrl.apply   = out_free;
         end
         default: ctrl.idle = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jmm_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: src/joystick_motor_mixer.sv
// A new sample is taken only when the previous one has left the sequencer; the
// 16-step square root dominates the work on each sample, together with five
// passes through the one shared multiplier.
// A sample can be accepted while the previous result still waits to be taken.
// Synchronous active-high reset: duties zero, LED off, both deadzones 1638,
// no result pending. Register writes are taken in every cycle.
// ---------------------------------------------------------------------------
// Joystick motor mixer
// Maps a joystick sample to PWM duties for the side and centre motors and
// an LED, using an iterative square root and one shared multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module joystick_motor_mixer (
   input  logic       clock,
   input  logic       reset,
   jmm_req_if.sink    req_chan,
   jmm_rsp_if.source  rsp_chan,
   jmm_csr_if.sink    csr_chan
);

   jmm_pkg::ctrl_type ctrl;

   // Configuration registers.
   logic [jmm_pkg::DZ_BITS-1:0] stick_dz_ff;
   logic [jmm_pkg::DZ_BITS-1:0] vert_dz_ff;

   // Captured sample. Magnitudes are one bit wider so full scale fits.
   logic [jmm_pkg::AXIS_BITS-1:0] x_ff;
   logic [jmm_pkg::AXIS_BITS-1:0] y_ff;
   logic                          v_neg_ff;
   logic [jmm_pkg::MAG_BITS-1:0]  x_mag_ff;
   logic [jmm_pkg::MAG_BITS-1:0]  u_mag_ff;
   logic [jmm_pkg::MAG_BITS-1:0]  v_mag_ff;
   logic [jmm_pkg::BTN_BITS-1:0]  btn_ff;

   // Intermediate results.
   logic [jmm_pkg::SQ_BITS-1:0]   sq_x_ff;
   logic [jmm_pkg::DUTY_BITS-1:0] scale_duty_ff;
   logic                          steep_ff;
   logic [jmm_pkg::PROD_BITS-1:0] prod;
   logic [jmm_pkg::MAG_BITS-1:0]  root;
   logic [jmm_pkg::MAG_BITS-1:0]  radius;

   // Motor and LED state; these registers also carry the result payload.
   logic [jmm_pkg::DUTY_BITS-1:0] duty_ff [jmm_pkg::CH_COUNT];
   logic [jmm_pkg::DUTY_BITS-1:0] duty_in [jmm_pkg::CH_COUNT];
   logic                          lamp_ff;
   logic                          lamp_in;
   logic                          quit_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;

   logic req_fire;
   logic out_free;

   assign req_chan.ready = ctrl.idle;
   assign req_fire       = req_chan.valid && ctrl.idle;
   // The result stage can take a new item when empty or emptying this cycle.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // ------------------------------------------------------------------
   // Register writes. Unknown indexes are ignored.
   // ------------------------------------------------------------------
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stick_dz_ff <= jmm_pkg::DZ_RESET;
         vert_dz_ff  <= jmm_pkg::DZ_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            jmm_pkg::CSR_STICK_DZ: stick_dz_ff <= csr_chan.data;
            jmm_pkg::CSR_VERT_DZ:  vert_dz_ff  <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Sample capture. The forward axis is the negated stick_y, so its
   // magnitude is that of stick_y and its sign is read from y_ff.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff     <= req_chan.stick_x;
         y_ff     <= req_chan.stick_y;
         v_neg_ff <= req_chan.vertical_axis[jmm_pkg::AXIS_BITS-1];
         x_mag_ff <= jmm_pkg::mag_of(req_chan.stick_x);
         u_mag_ff <= jmm_pkg::mag_of(req_chan.stick_y);
         v_mag_ff <= jmm_pkg::mag_of(req_chan.vertical_axis);
         btn_ff   <= req_chan.buttons;
      end
   end

   // ------------------------------------------------------------------
   // Shared arithmetic. The multiplier result is registered, so a state that
   // uses a product takes the one issued by the state before it.
   // ------------------------------------------------------------------
   jmm_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .out_free (out_free),
      .ctrl     (ctrl)
   );

   // The stick radius is limited to full scale before any further use.
   assign radius = (root > jmm_pkg::AXIS_FULL) ? jmm_pkg::AXIS_FULL : root;

   jmm_mul u_mul (
      .clock  (clock),
      .sel    (ctrl.mul_sel),
      .x_mag  (x_mag_ff),
      .u_mag  (u_mag_ff),
      .radius (radius),
      .prod   (prod)
   );

   jmm_root u_root (
      .clock    (clock),
      .load     (ctrl.root_load),
      .step     (ctrl.root_step),
      .idx      (ctrl.root_idx),
      .radicand (sq_x_ff + prod[jmm_pkg::SQ_BITS-1:0]),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (ctrl.sum_en) begin
         sq_x_ff <= prod[jmm_pkg::SQ_BITS-1:0];
      end
      // Weaker side duty: radius times (1 - |x|), truncated once.
      if (ctrl.scale_en) begin
         scale_duty_ff <= jmm_pkg::duty_q2(prod[jmm_pkg::SQ_BITS-1:0]);
      end
      // Steep backward: |u| * tan(22.5) >= |x|, i.e. at least 67.5 degrees.
      if (ctrl.steep_en) begin
         steep_ff <= prod >= {x_mag_ff, jmm_pkg::TAN_BITS'(0)};
      end
   end

   // ------------------------------------------------------------------
   // Mixing decision, evaluated in the last sequencer step.
   // ------------------------------------------------------------------
   logic                          quit;
   logic                          mid;
   logic                          x_pos;
   logic                          x_neg;
   logic                          u_pos;
   logic                          u_neg;
   logic                          u_zero;
   logic                          rev;
   logic [jmm_pkg::DUTY_BITS-1:0] dr;
   logic [jmm_pkg::DUTY_BITS-1:0] dv;

   assign quit   = btn_ff[jmm_pkg::BTN_QUIT];
   // At least 22.5 degrees from the horizontal; used only for backward samples.
   assign mid    = {u_mag_ff, jmm_pkg::TAN_BITS'(0)} >= prod;
   assign x_neg  = x_ff[jmm_pkg::AXIS_BITS-1];
   assign x_pos  = !x_neg && (x_ff != '0);
   assign u_zero = (y_ff == '0);
   assign u_pos  = y_ff[jmm_pkg::AXIS_BITS-1];
   assign u_neg  = !u_pos && !u_zero;
   assign rev    = (radius != '0);
   assign dr     = jmm_pkg::duty_q1(radius);
   assign dv     = jmm_pkg::duty_q1(v_mag_ff);

   always_comb begin
      duty_in = duty_ff;
      lamp_in = lamp_ff;
      if (!quit) begin
         // Centre motor follows the vertical axis on every non-quit sample.
         if (v_mag_ff < jmm_pkg::MAG_BITS'(vert_dz_ff)) begin
            duty_in[jmm_pkg::CH_DOWN] = '0;
            duty_in[jmm_pkg::CH_UP]   = '0;
         end else begin
            duty_in[jmm_pkg::CH_DOWN] = v_neg_ff ? '0 : dv;
            duty_in[jmm_pkg::CH_UP]   = v_neg_ff ? dv : '0;
         end

         if (btn_ff[jmm_pkg::BTN_SPIN_L]) begin
            // Spin left wins over spin right.
            duty_in[jmm_pkg::CH_LEFT_FWD]  = '0;
            duty_in[jmm_pkg::CH_LEFT_REV]  = jmm_pkg::DUTY_FULL;
            duty_in[jmm_pkg::CH_RIGHT_FWD] = jmm_pkg::DUTY_FULL;
            duty_in[jmm_pkg::CH_RIGHT_REV] = '0;
         end else if (btn_ff[jmm_pkg::BTN_SPIN_R]) begin
            duty_in[jmm_pkg::CH_LEFT_FWD]  = jmm_pkg::DUTY_FULL;
            duty_in[jmm_pkg::CH_LEFT_REV]  = '0;
            duty_in[jmm_pkg::CH_RIGHT_FWD] = '0;
            duty_in[jmm_pkg::CH_RIGHT_REV] = jmm_pkg::DUTY_FULL;
         end else begin
            if (btn_ff[jmm_pkg::BTN_LED]) begin
               lamp_in = !lamp_ff;
            end
            if (radius < jmm_pkg::MAG_BITS'(stick_dz_ff)) begin
               duty_in[jmm_pkg::CH_LEFT_FWD]  = '0;
               duty_in[jmm_pkg::CH_LEFT_REV]  = '0;
               duty_in[jmm_pkg::CH_RIGHT_FWD] = '0;
               duty_in[jmm_pkg::CH_RIGHT_REV] = '0;
            end else if ((!u_neg && x_pos) || (u_zero && !x_pos && !x_neg)) begin
               // Forward right quadrant: left at full radius, right scaled.
               duty_in[jmm_pkg::CH_LEFT_FWD]  = dr;
               duty_in[jmm_pkg::CH_LEFT_REV]  = '0;
               duty_in[jmm_pkg::CH_RIGHT_FWD] = scale_duty_ff;
               duty_in[jmm_pkg::CH_RIGHT_REV] = '0;
            end else if (u_pos) begin
               // Forward left quadrant: the mirror image.
               duty_in[jmm_pkg::CH_RIGHT_FWD] = dr;
               duty_in[jmm_pkg::CH_RIGHT_REV] = '0;
               duty_in[jmm_pkg::CH_LEFT_FWD]  = scale_duty_ff;
               duty_in[jmm_pkg::CH_LEFT_REV]  = '0;
            end else if (u_neg) begin
               if (steep_ff) begin
                  duty_in[jmm_pkg::CH_LEFT_FWD]  = rev ? '0 : dr;
                  duty_in[jmm_pkg::CH_LEFT_REV]  = rev ? dr : '0;
                  duty_in[jmm_pkg::CH_RIGHT_FWD] = rev ? '0 : dr;
                  duty_in[jmm_pkg::CH_RIGHT_REV] = rev ? dr : '0;
               end else if (mid && x_pos) begin
                  duty_in[jmm_pkg::CH_LEFT_FWD]  = rev ? '0 : dr;
                  duty_in[jmm_pkg::CH_LEFT_REV]  = rev ? dr : '0;
                  duty_in[jmm_pkg::CH_RIGHT_FWD] = '0;
                  duty_in[jmm_pkg::CH_RIGHT_REV] = '0;
               end else if (mid && x_neg) begin
                  duty_in[jmm_pkg::CH_RIGHT_FWD] = rev ? '0 : dr;
                  duty_in[jmm_pkg::CH_RIGHT_REV] = rev ? dr : '0;
                  duty_in[jmm_pkg::CH_LEFT_FWD]  = '0;
                  duty_in[jmm_pkg::CH_LEFT_REV]  = '0;
               end
               // Shallow backward directions leave the side motors as they were.
            end
            // Straight left with no forward component also holds the sides.
         end
      end
   end

   // ------------------------------------------------------------------
   // State and result stage.
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < jmm_pkg::CH_COUNT; i++) begin
            duty_ff[i] <= '0;
         end
         lamp_ff      <= 1'b0;
         quit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.apply) begin
            duty_ff <= duty_in;
            lamp_ff <= lamp_in;
            quit_ff <= quit;
         end
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.left_forward_duty  = duty_ff[jmm_pkg::CH_LEFT_FWD];
   assign rsp_chan.left_reverse_duty  = duty_ff[jmm_pkg::CH_LEFT_REV];
   assign rsp_chan.right_forward_duty = duty_ff[jmm_pkg::CH_RIGHT_FWD];
   assign rsp_chan.right_reverse_duty = duty_ff[jmm_pkg::CH_RIGHT_REV];
   assign rsp_chan.center_down_duty   = duty_ff[jmm_pkg::CH_DOWN];
   assign rsp_chan.center_up_duty     = duty_ff[jmm_pkg::CH_UP];
   assign rsp_chan.lamp_on            = lamp_ff;
   assign rsp_chan.quit_request       = quit_ff;

endmodule

`default_nettype wire

// File: src/jmm_checker.sv
// ---------------------------------------------------------------------------
// Joystick motor mixer checker
// Port-level assertions on the mixer, attached to the top level by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module jmm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [jmm_pkg::DUTY_BITS-1:0]     left_fwd,
   input logic [jmm_pkg::DUTY_BITS-1:0]     left_rev,
   input logic [jmm_pkg::DUTY_BITS-1:0]     right_fwd,
   input logic [jmm_pkg::DUTY_BITS-1:0]     right_rev,
   input logic [jmm_pkg::DUTY_BITS-1:0]     down,
   input logic [jmm_pkg::DUTY_BITS-1:0]     up,
   input logic                              lamp,
   input logic                              quit
);

   // A motor is never driven both ways at once.
   `JMM_ASSERT_SAME(a_no_opposed, clock, reset, rsp_valid, (left_fwd == '0 || left_rev == '0) && (right_fwd == '0 || right_rev == '0) && (down == '0 || up == '0), "motor driven in both directions")

   // The block works on one sample at a time.
   `JMM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "sample taken while busy")

   // A result offered but not taken stays offered.
   `JMM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result withdrawn before it was taken")

   // Its fields do not change while it waits.
   `JMM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable({left_fwd, left_rev, right_fwd, right_rev, down, up, lamp, quit}), "result changed while stalled")

endmodule

bind joystick_motor_mixer jmm_checker u_jmm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .left_fwd  (rsp_chan.left_forward_duty),
   .left_rev  (rsp_chan.left_reverse_duty),
   .right_fwd (rsp_chan.right_forward_duty),
   .right_rev (rsp_chan.right_reverse_duty),
   .down      (rsp_chan.center_down_duty),
   .up        (rsp_chan.center_up_duty),
   .lamp      (rsp_chan.lamp_on),
   .quit      (rsp_chan.quit_request)
);

`default_nettype wire
